[design/turret_inverse_kinematics_defines.svh]
// ---------------------------------------------------------------------------
// Turret inverse kinematics assertion macros
// Concurrent checks clocked by clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TURRET_INVERSE_KINEMATICS_DEFINES_SVH
`define TURRET_INVERSE_KINEMATICS_DEFINES_SVH

// check cons in the same cycle as ante
`define TIK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define TIK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tik_pkg.sv]
// ---------------------------------------------------------------------------
// Turret inverse kinematics package
// Widths, constants, pipeline records and per-stage step functions.
// ---------------------------------------------------------------------------
package tik_pkg;

    localparam int CORDIC_STAGES_DEF = 18;
    localparam int FRAC_BITS         = 16;
    localparam int GUARD_BITS        = 12;

    localparam int PW   = 18;   // position field width
    localparam int AW   = 19;   // angle field width
    localparam int EW   = 19;   // extension field width
    localparam int RW   = 17;   // config register width
    localparam int CFG_IW = 1;

    localparam int CW   = 34;   // CORDIC vector width
    localparam int ZW   = 35;   // CORDIC angle width, Q.30
    localparam int SQ_N = 30;   // square root steps
    localparam int SQ_W = 2 * SQ_N;
    localparam int SQ_RW = SQ_N + 2;
    localparam int FW   = 20;   // distance root width
    localparam int XW   = 21;   // extension working width

    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [ZW-1:0] HALF = {{(ZW-1){1'b0}}, 1'b1} << (SH - 1);

    localparam logic [CFG_IW-1:0] REG_BASE_HEIGHT = 1'b0;
    localparam logic [CFG_IW-1:0] REG_TOOL_OFFSET = 1'b1;
    localparam logic [RW-1:0] BASE_HEIGHT_RST = 17'd32768;
    localparam logic [RW-1:0] TOOL_OFFSET_RST = 17'd6554;

    localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [XW-1:0] EXT_HI_X = 21'sd262143;
    localparam logic signed [XW-1:0] EXT_LO_X = -21'sd262144;
    localparam logic signed [EW-1:0] EXT_HI = 19'sd262143;
    localparam logic signed [EW-1:0] EXT_LO = -19'sd262144;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    typedef struct packed {
        logic               sing;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [AW-1:0] dz;
        logic signed [AW-1:0] pyaw;
        logic signed [AW-1:0] ptilt;
    } carry_t;

    typedef struct packed {
        logic               sing;
        logic signed [AW-1:0] dz;
        logic signed [AW-1:0] pyaw;
        logic signed [AW-1:0] ptilt;
        logic [FW-1:0]      frnd;
    } meta_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cv_t;

    typedef struct packed {
        logic [SQ_RW-1:0] rem;
        logic [SQ_N-1:0]  root;
    } sq_t;

    typedef struct packed {
        carry_t           c;
        logic [SQ_W-1:0]  rv;
        logic [SQ_W-1:0]  sv;
        logic [SQ_RW-1:0] rrem;
        logic [SQ_RW-1:0] srem;
        logic [SQ_N-1:0]  rroot;
        logic [SQ_N-1:0]  sroot;
    } sqp_t;

    typedef struct packed {
        meta_t m;
        cv_t   yw;
        cv_t   tl;
    } cp_t;

    function automatic sq_t sqrt_step(input logic [SQ_RW-1:0] rem,
                                      input logic [SQ_N-1:0] root,
                                      input logic [1:0] bits);
        logic [SQ_RW-1:0] sh;
        logic [SQ_RW-1:0] trial;
        sq_t r;
        sh    = {rem[SQ_RW-3:0], bits};
        trial = {root, 2'b01};
        if (sh >= trial)
        begin
            r.rem  = sh - trial;
            r.root = {root[SQ_N-2:0], 1'b1};
        end
        else
        begin
            r.rem  = sh;
            r.root = {root[SQ_N-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic sqp_t sqrt_stage(input sqp_t a);
        sq_t  r1;
        sq_t  r2;
        sqp_t o;
        o  = a;
        r1 = sqrt_step(a.rrem, a.rroot, a.rv[SQ_W-1 -: 2]);
        r2 = sqrt_step(a.srem, a.sroot, a.sv[SQ_W-1 -: 2]);
        o.rrem  = r1.rem;
        o.rroot = r1.root;
        o.srem  = r2.rem;
        o.sroot = r2.root;
        o.rv    = {a.rv[SQ_W-3:0], 2'b00};
        o.sv    = {a.sv[SQ_W-3:0], 2'b00};
        return o;
    endfunction

    function automatic cv_t cordic_pre(input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y);
        cv_t r;
        if (x[CW-1])
        begin
            r.z = y[CW-1] ? -PI_Q30 : PI_Q30;
            r.x = -x;
            r.y = -y;
        end
        else
        begin
            r.z = '0;
            r.x = x;
            r.y = y;
        end
        return r;
    endfunction

    function automatic cv_t cordic_step(input cv_t a, input int i);
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] at;
        cv_t r;
        dx = a.y >>> i;
        dy = a.x >>> i;
        at = $signed({{(ZW-30){1'b0}}, ATAN_Q30[i[4:0]]});
        if (!a.y[CW-1])
        begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + at;
        end
        else
        begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - at;
        end
        return r;
    endfunction

    function automatic cp_t cordic_pair(input cp_t a, input int i);
        cp_t o;
        o    = a;
        o.yw = cordic_step(a.yw, i);
        o.tl = cordic_step(a.tl, i);
        return o;
    endfunction

endpackage

[design/turret_inverse_kinematics.sv]
// ---------------------------------------------------------------------------
// Turret inverse kinematics
// Yaw, tilt and extension of a rotate-tilt-extend arm for a target point.
// ---------------------------------------------------------------------------
// Input stream s_*: one target point and the current yaw/tilt per transfer.
// Output stream m_*: yaw, tilt and extension, with singular/saturated flags
// on m_tuser. Config channel cfg_*: index 0 base height, index 1 tool
// offset; cfg_ready is always high; write only while the block is empty.
// The pipeline has three entry stages (snapshot, squares, sums), a 30-step
// square-root pipeline, a pre-rotation stage, one stage per CORDIC iteration
// (yaw and tilt side by side) and two finishing stages (branch select,
// rounding and clipping).
// Throughput is one item per cycle while the output is not stalled. The
// whole pipeline advances together; when m_tvalid is high and m_tready low,
// every stage holds and s_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads the default base height (0.5 m)
// and tool offset (0.1 m).
// ---------------------------------------------------------------------------
`include "turret_inverse_kinematics_defines.svh"

module turret_inverse_kinematics #(
    parameter int CORDIC_STAGES = tik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [95:0]                s_tdata,   // target_x, target_y, target_z, prev_yaw, prev_tilt
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [63:0]                m_tdata,   // yaw, tilt, extension
    output logic [1:0]                 m_tuser,   // singular, saturated
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tik_pkg::CFG_IW-1:0] cfg_index,
    input  logic [tik_pkg::RW-1:0]     cfg_data
);

    localparam int DEPTH = 6 + tik_pkg::SQ_N + CORDIC_STAGES;
    localparam int SQ_N  = tik_pkg::SQ_N;
    localparam int XW    = tik_pkg::XW;
    localparam int AW    = tik_pkg::AW;
    localparam int FW    = tik_pkg::FW;
    localparam int CW    = tik_pkg::CW;
    localparam int ZW    = tik_pkg::ZW;

    logic                     en;
    logic [DEPTH-1:0]         vld_reg;
    logic [DEPTH-1:0]         vld_next;
    logic [tik_pkg::RW-1:0]   base_reg;
    logic [tik_pkg::RW-1:0]   offset_reg;

    tik_pkg::carry_t          c0_reg, c0_next;
    tik_pkg::carry_t          c1_reg;
    logic [34:0]              x2_reg, y2_reg;
    logic [35:0]              dz2_reg;
    logic signed [35:0]       x2_full, y2_full;
    logic signed [37:0]       dz2_full;
    tik_pkg::carry_t          c2_reg;
    logic [35:0]              r2_reg;
    logic [36:0]              s_reg;

    tik_pkg::sqp_t            sq0;
    tik_pkg::sqp_t            sq_in  [SQ_N];
    tik_pkg::sqp_t            sq_reg [SQ_N];

    tik_pkg::sqp_t            sq_last;
    tik_pkg::cp_t             p_reg, p_next;
    logic [FW-1:0]            f_root;
    logic [FW:0]              f_rem;
    logic signed [CW-1:0]     yx, yy, tx, ty;

    tik_pkg::cp_t             cd_in  [CORDIC_STAGES];
    tik_pkg::cp_t             cd_reg [CORDIC_STAGES];

    tik_pkg::cp_t             cl;
    logic signed [ZW-1:0]     tq;
    logic                     flip;
    tik_pkg::meta_t           m_f1_reg;
    logic signed [ZW-1:0]     yq_f1_reg, yq_f1_next;
    logic signed [ZW-1:0]     tilt_f1_reg, tilt_f1_next;
    logic signed [XW-1:0]     ext_f1_reg, ext_f1_next;

    logic signed [ZW-1:0]     yw;
    logic signed [AW-1:0]     yaw_reg, yaw_next;
    logic signed [AW-1:0]     tilt_reg, tilt_next;
    logic signed [AW-1:0]     ext_reg, ext_next;
    logic                     sing_reg;
    logic                     sat_reg, sat_next;

    assign en        = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[DEPTH-1];
    assign m_tdata   = {7'b0, ext_reg, tilt_reg, yaw_reg};
    assign m_tuser   = {sat_reg, sing_reg};
    assign cfg_ready = 1'b1;
    assign vld_next  = {vld_reg[DEPTH-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= tik_pkg::BASE_HEIGHT_RST;
            offset_reg <= tik_pkg::TOOL_OFFSET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tik_pkg::REG_BASE_HEIGHT: base_reg   <= cfg_data;
                tik_pkg::REG_TOOL_OFFSET: offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // entry snapshot
    always_comb
    begin
        c0_next.x     = s_tdata[17:0];
        c0_next.y     = s_tdata[35:18];
        c0_next.pyaw  = s_tdata[72:54];
        c0_next.ptilt = s_tdata[91:73];
        c0_next.dz    = $signed({s_tdata[53], s_tdata[53:36]}) - $signed({2'b00, base_reg});
        c0_next.sing  = (s_tdata[17:0] == '0) && (s_tdata[35:18] == '0);
    end

    assign x2_full  = c0_reg.x * c0_reg.x;
    assign y2_full  = c0_reg.y * c0_reg.y;
    assign dz2_full = c0_reg.dz * c0_reg.dz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg  <= c0_next;
            c1_reg  <= c0_reg;
            x2_reg  <= x2_full[34:0];
            y2_reg  <= y2_full[34:0];
            dz2_reg <= dz2_full[35:0];
            c2_reg  <= c1_reg;
            r2_reg  <= {1'b0, x2_reg} + {1'b0, y2_reg};
            s_reg   <= {2'b00, x2_reg} + {2'b00, y2_reg} + {1'b0, dz2_reg};
        end
    end

    // square roots: planar radius with guard bits, and full distance
    always_comb
    begin
        sq0.c     = c2_reg;
        sq0.rv    = {r2_reg, {(2 * tik_pkg::GUARD_BITS){1'b0}}};
        sq0.sv    = {{(tik_pkg::SQ_W - 37){1'b0}}, s_reg};
        sq0.rrem  = '0;
        sq0.srem  = '0;
        sq0.rroot = '0;
        sq0.sroot = '0;
    end

    genvar k;
    generate
        for (k = 0; k < SQ_N; k++)
        begin : g_sqrt
            if (k == 0)
            begin : g_first
                assign sq_in[k] = sq0;
            end
            else
            begin : g_next
                assign sq_in[k] = sq_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                    sq_reg[k] <= tik_pkg::sqrt_stage(sq_in[k]);
            end
        end
    endgenerate

    // distance rounding and CORDIC pre-rotation
    always_comb
    begin
        sq_last = sq_reg[SQ_N-1];
        f_root  = sq_last.sroot[FW-1:0];
        f_rem   = sq_last.srem[FW:0];
        yx = $signed({{(CW - tik_pkg::PW - tik_pkg::GUARD_BITS){sq_last.c.x[17]}},
                      sq_last.c.x, {tik_pkg::GUARD_BITS{1'b0}}});
        yy = $signed({{(CW - tik_pkg::PW - tik_pkg::GUARD_BITS){sq_last.c.y[17]}},
                      sq_last.c.y, {tik_pkg::GUARD_BITS{1'b0}}});
        tx = $signed({{(CW - AW - tik_pkg::GUARD_BITS){sq_last.c.dz[AW-1]}},
                      sq_last.c.dz, {tik_pkg::GUARD_BITS{1'b0}}});
        ty = -$signed({{(CW - SQ_N){1'b0}}, sq_last.rroot});
        p_next.m.sing  = sq_last.c.sing;
        p_next.m.dz    = sq_last.c.dz;
        p_next.m.pyaw  = sq_last.c.pyaw;
        p_next.m.ptilt = sq_last.c.ptilt;
        p_next.m.frnd  = f_root + {{(FW-1){1'b0}}, (f_rem > {1'b0, f_root})};
        p_next.yw      = tik_pkg::cordic_pre(yx, yy);
        p_next.tl      = tik_pkg::cordic_pre(tx, ty);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= p_next;
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_cordic
            if (i == 0)
            begin : g_first
                assign cd_in[i] = p_reg;
            end
            else
            begin : g_next
                assign cd_in[i] = cd_reg[i-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                    cd_reg[i] <= tik_pkg::cordic_pair(cd_in[i], i);
            end
        end
    endgenerate

    // branch select
    always_comb
    begin
        cl   = cd_reg[CORDIC_STAGES-1];
        tq   = (cl.tl.z + tik_pkg::HALF) >>> tik_pkg::SH;
        flip = (cl.m.ptilt > 0 && tq < 0) || (cl.m.ptilt < 0 && tq > 0);
        tilt_f1_next = flip ? -tq : tq;
        if (!flip)
            yq_f1_next = cl.yw.z;
        else if (cl.yw.z[ZW-1])
            yq_f1_next = cl.yw.z + tik_pkg::PI_Q30;
        else
            yq_f1_next = cl.yw.z - tik_pkg::PI_Q30;
        ext_f1_next = (cl.m.sing ? $signed({{(XW-AW){cl.m.dz[AW-1]}}, cl.m.dz})
                                 : $signed({{(XW-FW){1'b0}}, cl.m.frnd}))
                    - $signed({{(XW - tik_pkg::RW){1'b0}}, offset_reg});
    end

    // rounding and clipping
    always_comb
    begin
        yw        = (yq_f1_reg + tik_pkg::HALF) >>> tik_pkg::SH;
        yaw_next  = m_f1_reg.sing ? m_f1_reg.pyaw : yw[AW-1:0];
        tilt_next = m_f1_reg.sing ? '0 : tilt_f1_reg[AW-1:0];
        if (ext_f1_reg > tik_pkg::EXT_HI_X)
        begin
            ext_next = tik_pkg::EXT_HI;
            sat_next = 1'b1;
        end
        else if (ext_f1_reg < tik_pkg::EXT_LO_X)
        begin
            ext_next = tik_pkg::EXT_LO;
            sat_next = 1'b1;
        end
        else
        begin
            ext_next = ext_f1_reg[AW-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_f1_reg    <= cl.m;
            yq_f1_reg   <= yq_f1_next;
            tilt_f1_reg <= tilt_f1_next;
            ext_f1_reg  <= ext_f1_next;
            yaw_reg     <= yaw_next;
            tilt_reg    <= tilt_next;
            ext_reg     <= ext_next;
            sing_reg    <= m_f1_reg.sing;
            sat_reg     <= sat_next;
        end
    end

    `TIK_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken during output stall")
    `TIK_ASSERT_NEXT(a_valid_advance, en, vld_reg[DEPTH-1] == $past(vld_reg[DEPTH-2]), "valid lost or repeated")
    `TIK_ASSERT_NOW(a_singular_tilt, m_tvalid && sing_reg, tilt_reg == '0, "singular result with nonzero tilt")
    `TIK_ASSERT_NOW(a_sat_bound, m_tvalid && sat_reg, (ext_reg == tik_pkg::EXT_HI) || (ext_reg == tik_pkg::EXT_LO), "saturated extension off its bound")

endmodule
